// ===== rtl/bsra_pkg.sv =====
// The shared type, constants and helper function of the slab region allocator.
`default_nettype none

package bsra_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W = 5;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned INDEX_W = 12;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE = 1'b1;

  // Control from the sequencer to the word summary.
  typedef struct packed {
    logic clear;
    logic upd_en;
    logic upd_full;
  } sum_ctl_t;

  // Position of the lowest clear bit; bit 5 of the result is set when none is clear.
  function automatic logic [BIT_W:0] lowest_zero32(input logic [WORD_BITS-1:0] w);
    logic [BIT_W:0] r;
    r = 6'd32;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bsra_if.sv =====
// Request and response channel interfaces of the slab region allocator.
`default_nettype none

interface bsra_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [11:0] region_index;

  modport source (output valid, output mode, output region_index, input ready);
  modport sink (input valid, input mode, input region_index, output ready);
endinterface

interface bsra_rsp_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic [11:0] granted_index;
  logic [12:0] free_regions;

  modport source (output valid, output success, output granted_index,
                  output free_regions, input ready);
  modport sink (input valid, input success, input granted_index,
                input free_regions, output ready);
endinterface

`default_nettype wire

// ===== rtl/bitmap_slab_region_allocator_unit.sv =====
// Top level of the slab region allocator: sequencer, map memory and word summary.
//
//   channel  dir  handshake         payload
//   req      in   valid / ready     mode, region_index
//   rsp      out  valid / ready     success, granted_index, free_regions
//   cfg      in   cfg_wr_en         cfg_wr_data (region_count)
//
// An allocate passes through accept, word search, map read and result; a free
// passes through accept with map read, read-modify-write and result; the map memory's
// registered read followed by the write-back sets this order. An allocate that
// sees every word full, or a free out of range, skips the read-modify-write step.
// Reset and a region_count write empty the slab at once through per-word valid flags.
// A stalled response holds in the output register while the next request is taken.
`default_nettype none

module bitmap_slab_region_allocator_unit #(
  parameter int unsigned MAX_REGIONS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  bsra_req_if.sink         req,
  bsra_rsp_if.source       rsp,
  input  wire logic        cfg_wr_en,
  input  wire logic [12:0] cfg_wr_data
);

  localparam int unsigned WORDS = (MAX_REGIONS + 31) / 32;
  localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned XW0 = (AW + 5 > CW) ? AW + 5 : CW;
  localparam int unsigned XW = (XW0 > 13) ? XW0 : 13;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIND = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]         state;
  logic [12:0]        region_count;
  logic [CW-1:0]      free_count;
  logic               mode_q;
  logic [11:0]        idx_q;
  logic [AW-1:0]      addr_q;
  logic               res_ok;
  logic [11:0]        res_idx;

  logic [XW-1:0]      max_x;
  logic [XW-1:0]      eff_x;
  logic [XW-1:0]      cfg_x;
  logic [XW-1:0]      cfg_eff_x;
  logic [XW-1:0]      idx_x;
  logic [XW-1:0]      pos_x;
  logic [XW-1:0]      free_x;
  logic [CW-1:0]      eff_count;
  logic [AW-1:0]      widx;

  logic               accept;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic               ram_we;
  logic [31:0]        ram_wdata;
  logic [31:0]        rdata;
  logic [31:0]        cur;
  logic [5:0]         lz;
  logic [31:0]        set_word;
  logic [31:0]        clr_word;
  logic               alloc_ok;
  logic               bit_set;
  logic               op_ok;

  bsra_pkg::sum_ctl_t sum_ctl;
  logic               look_valid;
  logic               found;
  logic [AW-1:0]      find_addr;

  // Effective region count: values above capacity act as capacity.
  assign max_x = XW'(MAX_REGIONS);
  assign eff_x = (XW'(region_count) > max_x) ? max_x : XW'(region_count);
  assign eff_count = CW'(eff_x);
  assign cfg_x = XW'(cfg_wr_data);
  assign cfg_eff_x = (cfg_x > max_x) ? max_x : cfg_x;

  assign idx_x = XW'(req.region_index);
  assign widx = idx_x[AW+4:5];

  assign req.ready = (state == S_IDLE) && !rst;
  assign accept = req.valid && req.ready;

  always_comb begin
    ram_re = 1'b0;
    ram_raddr = widx;
    if (accept && req.mode == bsra_pkg::MODE_FREE) begin
      ram_re = (idx_x < eff_x);
    end else if (state == S_FIND) begin
      ram_re = found;
      ram_raddr = find_addr;
    end
  end

  // Read-modify-write of the selected map word.
  assign cur = look_valid ? rdata : '0;
  assign lz = bsra_pkg::lowest_zero32(cur);
  assign pos_x = XW'({addr_q, lz[4:0]});
  assign alloc_ok = !lz[5] && (pos_x < eff_x);
  assign set_word = cur | (32'd1 << lz[4:0]);
  assign clr_word = cur & ~(32'd1 << idx_q[4:0]);
  assign bit_set = cur[idx_q[4:0]];
  assign op_ok = (mode_q == bsra_pkg::MODE_FREE) ? bit_set : alloc_ok;
  assign ram_we = (state == S_READ) && op_ok;
  assign ram_wdata = (mode_q == bsra_pkg::MODE_FREE) ? clr_word : set_word;

  always_comb begin
    sum_ctl.clear = cfg_wr_en;
    sum_ctl.upd_en = ram_we;
    sum_ctl.upd_full = &ram_wdata;
  end

  bsra_ram #(
    .WIDTH(32),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr_q),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  bsra_summary #(
    .WORDS(WORDS)
  ) u_summary (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sum_ctl),
    .upd_addr  (addr_q),
    .look_addr (addr_q),
    .look_valid(look_valid),
    .found     (found),
    .find_addr (find_addr)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= req.mode;
      idx_q <= req.region_index;
    end
    if (ram_re) begin
      addr_q <= ram_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      region_count <= bsra_pkg::COUNT_RESET;
      free_count <= CW'((XW'(bsra_pkg::COUNT_RESET) > max_x) ? max_x
                        : XW'(bsra_pkg::COUNT_RESET));
      res_ok <= 1'b0;
      res_idx <= '0;
    end else begin
      if (cfg_wr_en) begin
        region_count <= cfg_wr_data;
        free_count <= CW'(cfg_eff_x);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_ok <= 1'b0;
            res_idx <= '0;
            if (req.mode == bsra_pkg::MODE_ALLOC) begin
              state <= S_FIND;
            end else if (idx_x < eff_x) begin
              state <= S_READ;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_FIND: begin
          state <= found ? S_READ : S_EMIT;
        end
        S_READ: begin
          if (op_ok) begin
            res_ok <= 1'b1;
            if (mode_q == bsra_pkg::MODE_FREE) begin
              if (free_count < eff_count) begin
                free_count <= free_count + CW'(1);
              end
            end else begin
              res_idx <= pos_x[11:0];
              if (free_count != '0) begin
                free_count <= free_count - CW'(1);
              end
            end
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!rsp.valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded when the result is ready and the slot is empty or being taken.
  assign free_x = XW'(free_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_EMIT && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!rsp.valid || rsp.ready)) begin
      rsp.success <= res_ok;
      rsp.granted_index <= res_idx;
      rsp.free_regions <= free_x[12:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bsra_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bsra_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bsra_summary.sv =====
// Per-word valid and full flags with a two-level search for the first word with room.
`default_nettype none

module bsra_summary #(
  parameter int unsigned WORDS = 128,
  localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1,
  localparam int unsigned GROUPS = (WORDS + 31) / 32,
  localparam int unsigned GW = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bsra_pkg::sum_ctl_t ctl,
  input  wire logic [AW-1:0]     upd_addr,
  input  wire logic [AW-1:0]     look_addr,
  output logic                   look_valid,
  output logic                   found,
  output logic [AW-1:0]          find_addr
);

  logic [WORDS-1:0]       valid;
  logic [WORDS-1:0]       full;
  logic [GROUPS*32-1:0]   full_pad;
  logic [31:0]            grp_busy;
  logic [5:0]             gsel;
  logic [5:0]             wsel;
  logic                   grp_any;
  logic [GW-1:0]          grp_idx;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= '0;
      full <= '0;
    end else if (ctl.upd_en) begin
      valid[upd_addr] <= 1'b1;
      full[upd_addr] <= ctl.upd_full;
    end
  end

  // Words past the end of the map read as full so the search never picks them.
  always_comb begin
    full_pad = '1;
    full_pad[WORDS-1:0] = full;
    grp_busy = '1;
    for (int g = 0; g < GROUPS; g++) begin
      grp_busy[g] = &full_pad[g*32 +: 32];
    end
  end

  assign gsel = bsra_pkg::lowest_zero32(grp_busy);

  // The group choice is registered every cycle; the flags change on a write-back, a
  // clear or reset, and after a write-back it is current again before the next search.
  always_ff @(posedge clk) begin
    grp_any <= ~gsel[5];
    grp_idx <= gsel[GW-1:0];
  end

  assign wsel = bsra_pkg::lowest_zero32(full_pad[{grp_idx, 5'b0} +: 32]);
  assign find_addr = AW'({grp_idx, wsel[4:0]});
  assign found = grp_any;
  assign look_valid = valid[look_addr];

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the slab region allocator: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_REGIONS = 4096;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int PHASES = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int INDEX_W = bsra_pkg::INDEX_W;
  localparam int COUNT_W = bsra_pkg::COUNT_W;

  typedef struct packed {
    logic               success;
    logic [INDEX_W-1:0] granted_index;
    logic [COUNT_W-1:0] free_regions;
  } alloc_result_t;

  typedef enum {ROW_ALLOC, ROW_FREE, ROW_SET_COUNT} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [COUNT_W-1:0] arg;
    bit                 typed;
    alloc_result_t      want;
  } directed_row_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;

  bsra_req_if alloc_req();
  bsra_rsp_if alloc_rsp();

  // Shadow of the slab: used bits, free count and the usable region limit.
  bit [MAX_REGIONS-1:0] used_bits;
  int region_lim;
  int free_cnt;

  alloc_result_t pending_results[$];
  logic [INDEX_W-1:0] granted_q[$];
  directed_row_t directed_rows[$];

  // Typed-in expectation that travels with the request currently offered.
  bit row_typed;
  alloc_result_t row_expect;

  int err_count;
  int stall_cycles;
  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_ticket;
  int hold_served;
  int hold_left;

  bitmap_slab_region_allocator_unit #(.MAX_REGIONS(MAX_REGIONS)) u_top (
    .clk(clk),
    .rst(rst),
    .req(alloc_req),
    .rsp(alloc_rsp),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  function automatic void set_region_count(input logic [COUNT_W-1:0] value);
    region_lim = (int'(value) > MAX_REGIONS) ? MAX_REGIONS : int'(value);
    used_bits = '0;
    free_cnt = region_lim;
    granted_q.delete();
  endfunction

  function automatic alloc_result_t predict_request(input logic mode,
                                                    input logic [INDEX_W-1:0] idx);
    alloc_result_t r;
    int pos;
    r = '0;
    if (mode == bsra_pkg::MODE_ALLOC) begin
      // Bits at or above the limit are never set, so the first clear bit decides.
      pos = 0;
      while (pos < region_lim && used_bits[pos]) pos++;
      if (pos < region_lim) begin
        used_bits[pos] = 1'b1;
        if (free_cnt > 0) free_cnt--;
        r.success = 1'b1;
        r.granted_index = INDEX_W'(pos);
      end
    end else if (int'(idx) < region_lim && used_bits[idx]) begin
      used_bits[idx] = 1'b0;
      if (free_cnt < region_lim) free_cnt++;
      r.success = 1'b1;
    end
    r.free_regions = COUNT_W'(free_cnt);
    return r;
  endfunction

  function automatic void add_row(input row_kind_t kind, input int arg, input bit typed = 1'b0,
                                  input bit ok = 1'b0, input int grant = 0, input int free = 0);
    directed_row_t row;
    row.kind = kind;
    row.arg = COUNT_W'(arg);
    row.typed = typed;
    row.want.success = ok;
    row.want.granted_index = INDEX_W'(grant);
    row.want.free_regions = COUNT_W'(free);
    directed_rows.push_back(row);
  endfunction

  task automatic send_request(input logic mode, input logic [INDEX_W-1:0] idx,
                              input bit typed, input alloc_result_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      alloc_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    alloc_req.valid <= 1'b1;
    alloc_req.mode <= mode;
    alloc_req.region_index <= idx;
    row_typed <= typed;
    row_expect <= want;
    @(posedge clk);
    while (!alloc_req.ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    alloc_req.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_region_count(input logic [COUNT_W-1:0] value);
    wait_for_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Response check against the oldest expectation, then prediction of new transfers.
  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    alloc_result_t predicted;
    if (rst) begin
      set_region_count(bsra_pkg::COUNT_RESET);
      pending_results.delete();
    end else begin
      if (alloc_rsp.valid && alloc_rsp.ready) begin
        got.success = alloc_rsp.success;
        got.granted_index = alloc_rsp.granted_index;
        got.free_regions = alloc_rsp.free_regions;
        if (pending_results.size() == 0) begin
          $display("%0t: response with nothing pending: success %0d index %0d free %0d",
                   $time, got.success, got.granted_index, got.free_regions);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.success !== want.success) begin
            $display("%0t: success expected %0d actual %0d", $time, want.success, got.success);
            err_count++;
          end
          if (got.granted_index !== want.granted_index) begin
            $display("%0t: granted_index expected %0d actual %0d", $time,
                     want.granted_index, got.granted_index);
            err_count++;
          end
          if (got.free_regions !== want.free_regions) begin
            $display("%0t: free_regions expected %0d actual %0d", $time,
                     want.free_regions, got.free_regions);
            err_count++;
          end
        end
      end
      if (cfg_wr_en) set_region_count(cfg_wr_data);
      if (alloc_req.valid && alloc_req.ready) begin
        predicted = predict_request(alloc_req.mode, alloc_req.region_index);
        if (alloc_req.mode == bsra_pkg::MODE_ALLOC && predicted.success)
          granted_q.push_back(predicted.granted_index);
        pending_results.push_back(row_typed ? row_expect : predicted);
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold whenever a new ticket is raised.
  always @(posedge clk) begin
    if (rst) begin
      alloc_rsp.ready <= 1'b0;
    end else if (hold_served != hold_ticket) begin
      hold_served <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      alloc_rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      alloc_rsp.ready <= 1'b0;
    end else begin
      alloc_rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (alloc_req.valid && alloc_req.ready) || (alloc_rsp.valid && alloc_rsp.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int r;
    int k;
    logic [INDEX_W-1:0] idx;
    logic [COUNT_W-1:0] cnt;
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    alloc_req.valid = 1'b0;
    alloc_req.mode = bsra_pkg::MODE_ALLOC;
    alloc_req.region_index = '0;
    alloc_rsp.ready = 1'b0;
    row_typed = 1'b0;
    row_expect = '0;
    err_count = 0;
    stall_cycles = 0;
    hold_ticket = 0;
    hold_served = 0;
    hold_left = 0;
    snd_idle_pct = 9;
    rcv_idle_pct = 51;

    // Full-capacity slab after reset: lowest-bit grants, double free, free of a clear bit.
    add_row(ROW_ALLOC, 0, 1, 1, 0, 4095);
    add_row(ROW_ALLOC, 0, 1, 1, 1, 4094);
    add_row(ROW_FREE, 0, 1, 1, 0, 4095);
    add_row(ROW_FREE, 0, 1, 0, 0, 4095);
    add_row(ROW_FREE, 4095, 1, 0, 0, 4095);
    add_row(ROW_ALLOC, 0, 1, 1, 0, 4094);
    add_row(ROW_FREE, 2048, 1, 0, 0, 4094);
    // One region: full slab and an out-of-range free.
    add_row(ROW_SET_COUNT, 1);
    add_row(ROW_ALLOC, 4095, 1, 1, 0, 0);
    add_row(ROW_ALLOC, 0, 1, 0, 0, 0);
    add_row(ROW_FREE, 1, 1, 0, 0, 0);
    add_row(ROW_FREE, 4095, 1, 0, 0, 0);
    add_row(ROW_FREE, 0, 1, 1, 0, 1);
    // A zero count leaves no usable region at all.
    add_row(ROW_SET_COUNT, 0);
    add_row(ROW_ALLOC, 0, 1, 0, 0, 0);
    add_row(ROW_FREE, 0, 1, 0, 0, 0);
    // A count above capacity behaves as the full capacity.
    add_row(ROW_SET_COUNT, 8191);
    add_row(ROW_ALLOC, 0, 1, 1, 0, 4095);
    add_row(ROW_FREE, 4095, 1, 0, 0, 4095);
    add_row(ROW_SET_COUNT, 3);
    add_row(ROW_ALLOC, 0, 1, 1, 0, 2);
    add_row(ROW_ALLOC, 0, 1, 1, 1, 1);
    add_row(ROW_FREE, 0, 1, 1, 0, 2);
    add_row(ROW_ALLOC, 0);
    add_row(ROW_ALLOC, 0);
    add_row(ROW_ALLOC, 0, 1, 0, 0, 0);
    add_row(ROW_FREE, 2);
    add_row(ROW_SET_COUNT, 4096);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_SET_COUNT: write_region_count(directed_rows[i].arg);
        ROW_FREE: send_request(bsra_pkg::MODE_FREE, directed_rows[i].arg[INDEX_W-1:0],
                               directed_rows[i].typed, directed_rows[i].want);
        default: send_request(bsra_pkg::MODE_ALLOC, directed_rows[i].arg[INDEX_W-1:0],
                              directed_rows[i].typed, directed_rows[i].want);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 4) begin
        snd_idle_pct = 51;
        rcv_idle_pct = 9;
      end else if (p == 8) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case (p)
        0: cnt = bsra_pkg::COUNT_RESET;
        1: cnt = 13'd1;
        5: cnt = 13'h1FFF;
        7: cnt = '0;
        11: cnt = COUNT_W'($urandom_range(8191, 4097));
        default: cnt = ($urandom_range(3) == 0) ? COUNT_W'($urandom_range(4096, 65))
                                                 : COUNT_W'($urandom_range(64, 1));
      endcase
      write_region_count(cnt);
      // The receiver stops for a long stretch while requests keep coming.
      if (p == 2) hold_ticket++;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(99);
        if (r < 50) begin
          send_request(bsra_pkg::MODE_ALLOC, INDEX_W'($urandom()), 1'b0, '0);
        end else begin
          if (r < 85 && granted_q.size() > 0) begin
            k = $urandom_range(granted_q.size() - 1);
            idx = granted_q[k];
            granted_q.delete(k);
          end else if (r < 93 && region_lim > 0) begin
            idx = INDEX_W'($urandom_range(region_lim - 1, 0));
          end else begin
            idx = INDEX_W'($urandom());
          end
          send_request(bsra_pkg::MODE_FREE, idx, 1'b0, '0);
        end
      end
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
